// ----- hdl/max_heap_priority_queue_defines.svh -----
// assertion macros for the max heap priority queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTH
`define MHPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MHPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/mhpq_pkg.sv -----
// types, codes and defaults shared by the max heap priority queue
package mhpq_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int PAYLOAD_W    = 16;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 7;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] priority_key;
        logic [PAYLOAD_W-1:0]    payload;
    } req_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] top_key;
        logic [PAYLOAD_W-1:0]    top_payload;
        logic [COUNT_W-1:0]      entry_count;
    } rsp_word_t;
endpackage

// ----- hdl/mhpq_mem.sv -----
// heap entry memory, one write port and one registered read port
module mhpq_mem #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  mhpq_pkg::entry_t            wr_data,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output mhpq_pkg::entry_t            rd_data
);
    mhpq_pkg::entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- hdl/mhpq_ctrl.sv -----
// sift sequencer: insert, extract and peek over the entry memory
`include "max_heap_priority_queue_defines.svh"
module mhpq_ctrl #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_accept,
    input  mhpq_pkg::req_word_t         req_word,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mhpq_pkg::rsp_word_t         res_word,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output mhpq_pkg::entry_t            wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  mhpq_pkg::entry_t            rd_data
);
    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = IW + 2;
    localparam int SW  = 3;

    localparam logic [SW-1:0] S_IDLE    = 3'd0;
    localparam logic [SW-1:0] S_UP      = 3'd1;
    localparam logic [SW-1:0] S_EX_ROOT = 3'd2;
    localparam logic [SW-1:0] S_EX_LAST = 3'd3;
    localparam logic [SW-1:0] S_DN_L    = 3'd4;
    localparam logic [SW-1:0] S_DN_R    = 3'd5;
    localparam logic [SW-1:0] S_WR      = 3'd6;
    localparam logic [SW-1:0] S_DONE    = 3'd7;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [SW-1:0]    state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [1:0]       status_reg, status_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [IW-1:0]    pos_reg, pos_next;
    mhpq_pkg::entry_t cur_reg, cur_next;
    mhpq_pkg::entry_t left_reg, left_next;
    mhpq_pkg::entry_t top_reg, top_next;

    logic [XW-1:0]    lidx, ridx, occ_x, bidx, blidx;
    logic [IW-1:0]    par_idx, occ_par;
    logic [CW-1:0]    occ_dec;
    mhpq_pkg::entry_t best;

    always_comb
    begin
        lidx    = {1'b0, pos_reg, 1'b1};
        ridx    = XW'({pos_reg, 1'b0}) + XW'(2);
        occ_x   = XW'(occ_reg);
        par_idx = (pos_reg - IW'(1)) >> 1;
        occ_par = (occ_reg[IW-1:0] - IW'(1)) >> 1;
        occ_dec = occ_reg - CW'(1);
        best    = cur_reg;
        bidx    = XW'(pos_reg);
        if (cur_reg.key < left_reg.key)
        begin
            best = left_reg;
            bidx = lidx;
        end
        if (best.key < rd_data.key)
        begin
            best = rd_data;
            bidx = ridx;
        end
        blidx = {bidx[XW-2:0], 1'b1};
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        occ_next    = occ_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = cur_reg;
        rd_addr     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    cmd_next    = req_word.command;
                    status_next = mhpq_pkg::ST_DONE;
                    top_next    = '0;
                    state_next  = S_DONE;
                    if (req_word.command == mhpq_pkg::CMD_INSERT)
                    begin
                        if (occ_reg == CAP_C)
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cur_next.key = req_word.priority_key;
                            cur_next.tag = req_word.payload;
                            pos_next     = occ_reg[IW-1:0];
                            occ_next     = occ_reg + CW'(1);
                            if (occ_reg == '0)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = cur_next;
                            end
                            else
                            begin
                                rd_addr    = occ_par;
                                state_next = S_UP;
                            end
                        end
                    end
                    else if (req_word.command == mhpq_pkg::CMD_EXTRACT ||
                             req_word.command == mhpq_pkg::CMD_PEEK)
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = mhpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            state_next = S_EX_ROOT;
                        end
                    end
                end
            end
            S_UP:
            begin
                wr_en = 1'b1;
                if (rd_data.key < cur_reg.key)
                begin
                    wr_data  = rd_data;
                    pos_next = par_idx;
                    if (par_idx == '0)
                    begin
                        state_next = S_WR;
                    end
                    else
                    begin
                        rd_addr = (par_idx - IW'(1)) >> 1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EX_ROOT:
            begin
                top_next   = rd_data;
                state_next = S_DONE;
                if (cmd_reg == mhpq_pkg::CMD_EXTRACT)
                begin
                    occ_next = occ_dec;
                    if (occ_dec != '0)
                    begin
                        rd_addr    = occ_dec[IW-1:0];
                        state_next = S_EX_LAST;
                    end
                end
            end
            S_EX_LAST:
            begin
                cur_next = rd_data;
                pos_next = '0;
                if (occ_reg > CW'(1))
                begin
                    rd_addr    = IW'(1);
                    state_next = S_DN_L;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = rd_data;
                    state_next = S_DONE;
                end
            end
            S_DN_L:
            begin
                left_next = rd_data;
                if (ridx < occ_x)
                begin
                    rd_addr    = ridx[IW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (cur_reg.key < rd_data.key)
                    begin
                        wr_data    = rd_data;
                        pos_next   = lidx[IW-1:0];
                        state_next = S_WR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DN_R:
            begin
                wr_en = 1'b1;
                if (bidx == XW'(pos_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_data  = best;
                    pos_next = bidx[IW-1:0];
                    if (blidx < occ_x)
                    begin
                        rd_addr    = blidx[IW-1:0];
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
            end
            S_WR:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
    end

    assign idle                 = (state_reg == S_IDLE);
    assign res_valid            = (state_reg == S_DONE);
    assign res_word.status      = status_reg;
    assign res_word.top_key     = top_reg.key;
    assign res_word.top_payload = top_reg.tag;
    assign res_word.entry_count = mhpq_pkg::COUNT_W'(occ_reg);

    `MHPQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= CAP_C, "occupancy above capacity")
    `MHPQ_ASSERT_NEXT(a_accept_busy, req_accept, state_reg != S_IDLE, "accept left block idle")
    `MHPQ_ASSERT_SAME(a_no_overlap, wr_en && rd_addr != '0, wr_addr != rd_addr, "entry collision")
    `MHPQ_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_word), "result lost")
endmodule

// ----- hdl/max_heap_priority_queue.sv -----
// top level of the max heap priority queue
// usage:
//   req channel (req_valid, req_stall, req_word) takes one command word:
//   insert, extract maximum or peek maximum.
//   rsp channel (rsp_valid, rsp_stall, rsp_word) returns one word per
//   command: status, top entry and the entry count after the command.
// sequence: full, empty and unused commands go straight to the result;
//   peek reads the root; insert climbs level by level; extract reads
//   the root and the last entry, then descends level by level, since each level
//   reads both children through the single read port of the entry memory.
// throughput: one command at a time; req_stall is high while a command
//   is in progress.
// reset: count cleared, memory contents left undefined; entries are only
//   read after being written.
// a stalled response is held in the output register; the next command may
//   be taken meanwhile and its result waits until the register frees.
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mhpq_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mhpq_pkg::rsp_word_t rsp_word
);
    localparam int IW = $clog2(CAPACITY);

    logic                rsp_valid_reg, rsp_valid_next;
    mhpq_pkg::rsp_word_t rsp_word_reg, rsp_word_next;
    logic                idle, res_valid, res_ready, req_accept;
    mhpq_pkg::rsp_word_t res_word;
    logic                wr_en;
    logic [IW-1:0]       wr_addr, rd_addr;
    mhpq_pkg::entry_t    wr_data, rd_data;

    assign req_stall  = !idle;
    assign req_accept = req_valid && idle;
    assign res_ready  = !rsp_valid_reg || !rsp_stall;

    mhpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .req_word   (req_word),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    mhpq_mem #(.CAPACITY(CAPACITY)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;
endmodule
